FILE: sv/sfpx_pkg.sv
// ----------------------------------------------------------------------------
// sfpx_pkg
// Shared types and constants of the serial frame parser with XOR checksum.
// ----------------------------------------------------------------------------
`default_nettype none

package sfpx_pkg;

    // Default payload buffer depth per bank
    localparam int PAYLOAD_DEPTH_DEF = 64;

    // Width of payload length and fill counters (holds up to 127)
    localparam int LEN_W = 7;

    // Frame framing bytes
    localparam logic [7:0] START_FIRST  = 8'hF1;
    localparam logic [7:0] START_SECOND = 8'hF2;
    localparam logic [7:0] FIXED_FIELDS = 8'd3;

    // Configuration register indexes
    localparam int         CFG_IDX_W          = 2;
    localparam logic [1:0] CFG_ID_SYS         = 2'd0;
    localparam logic [1:0] CFG_ID_INERTIAL    = 2'd1;
    localparam logic [1:0] CFG_ID_LIGHT_MOTOR = 2'd2;

    // Front parser phases
    typedef enum logic [2:0] {
        PH_START1,
        PH_START2,
        PH_LENGTH,
        PH_COUNT,
        PH_KIND,
        PH_PAYLOAD,
        PH_CHECK
    } t_phase;

    // Back drain states
    typedef enum logic [1:0] {
        B_IDLE,
        B_LOAD,
        B_OUT
    } t_bstate;

    // Completed-frame descriptor passed from front to back
    typedef struct packed {
        logic             bank;
        logic [LEN_W-1:0] len;
        logic [7:0]       kind;
        logic [7:0]       count;
        logic             ok;
        logic [31:0]      good;
        logic [31:0]      bad;
    } t_desc;

    // Payload buffer write request
    typedef struct packed {
        logic             en;
        logic             bank;
        logic [LEN_W-1:0] idx;
        logic [7:0]       data;
    } t_wr;

    // Bank release from back to front
    typedef struct packed {
        logic valid;
        logic bank;
    } t_free;

endpackage

`default_nettype wire

FILE: sv/sfpx_front.sv
// ----------------------------------------------------------------------------
// sfpx_front
// Hunts for frames, checks length and id, writes payload into the current
// buffer bank and queues one descriptor per finished frame.
// ----------------------------------------------------------------------------
`default_nettype none

module sfpx_front
    import sfpx_pkg::*;
#(
    parameter int PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [7:0]           i_cfg_data,
    output logic                      o_cfg_ready,
    input  wire logic                 i_rx_valid,
    input  wire logic [7:0]           i_rx_byte,
    output logic                      o_rx_ready,
    input  wire logic                 i_q_full,
    output logic                      o_push,
    output t_desc                     o_desc,
    output t_wr                       o_wr,
    input  wire t_free                i_free
);

    localparam logic [8:0] MAX_LEN = 9'(PAYLOAD_DEPTH + 3);

    t_phase           r_phase, n_phase;
    logic [7:0]       r_id_sys, r_id_inertial, r_id_light;
    logic [7:0]       r_count, r_kind, r_xor;
    logic [LEN_W-1:0] r_plen, r_fill;
    logic [31:0]      r_good, r_bad;
    logic             r_bank;
    logic [1:0]       r_busy, n_busy;

    logic             rx_acc;
    logic             id_hit;
    logic             len_ok;
    logic [LEN_W-1:0] fill_next;
    logic             sum_ok;

    assign o_cfg_ready = 1'b1;
    assign rx_acc      = i_rx_valid && o_rx_ready;
    assign id_hit      = (i_rx_byte == r_id_sys) || (i_rx_byte == r_id_inertial) ||
                         (i_rx_byte == r_id_light);
    assign len_ok      = (i_rx_byte > FIXED_FIELDS) && ({1'b0, i_rx_byte} <= MAX_LEN);
    assign fill_next   = r_fill + LEN_W'(1);
    assign sum_ok      = (i_rx_byte == r_xor);

    // Advance the frame phase on each accepted byte
    always_comb begin
        n_phase = r_phase;
        if (rx_acc) begin
            unique case (r_phase)
                PH_START1:  n_phase = (i_rx_byte == START_FIRST) ? PH_START2 : PH_START1;
                PH_START2:  n_phase = (i_rx_byte == START_SECOND) ? PH_LENGTH : PH_START1;
                PH_LENGTH:  n_phase = len_ok ? PH_COUNT : PH_START1;
                PH_COUNT:   n_phase = PH_KIND;
                PH_KIND:    n_phase = id_hit ? PH_PAYLOAD : PH_START1;
                PH_PAYLOAD: n_phase = (fill_next >= r_plen) ? PH_CHECK : PH_PAYLOAD;
                PH_CHECK:   n_phase = PH_START1;
                default:    n_phase = PH_START1;
            endcase
        end
    end

    // Stall on a held bank or a full queue; build write and descriptor
    always_comb begin
        o_rx_ready = !((r_phase == PH_PAYLOAD && r_busy[r_bank]) ||
                       (r_phase == PH_CHECK && i_q_full));
        o_wr.en    = rx_acc && (r_phase == PH_PAYLOAD);
        o_wr.bank  = r_bank;
        o_wr.idx   = r_fill;
        o_wr.data  = i_rx_byte;
        o_push     = rx_acc && (r_phase == PH_CHECK);
        o_desc.bank  = r_bank;
        o_desc.len   = r_plen;
        o_desc.kind  = r_kind;
        o_desc.count = r_count;
        o_desc.ok    = sum_ok;
        o_desc.good  = r_good + {31'd0, sum_ok};
        o_desc.bad   = r_bad + {31'd0, !sum_ok};
    end

    // Release a drained bank and claim the bank of a good frame
    always_comb begin
        n_busy = r_busy;
        if (i_free.valid) begin
            n_busy[i_free.bank] = 1'b0;
        end
        if (o_push && sum_ok) begin
            n_busy[r_bank] = 1'b1;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id_sys      <= '0;
            r_id_inertial <= '0;
            r_id_light    <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_ID_SYS:         r_id_sys      <= i_cfg_data;
                CFG_ID_INERTIAL:    r_id_inertial <= i_cfg_data;
                CFG_ID_LIGHT_MOTOR: r_id_light    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Phase, counters and bank ownership
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START1;
            r_good  <= '0;
            r_bad   <= '0;
            r_bank  <= 1'b0;
            r_busy  <= '0;
        end else begin
            r_phase <= n_phase;
            r_busy  <= n_busy;
            if (o_push) begin
                r_good <= o_desc.good;
                r_bad  <= o_desc.bad;
                if (sum_ok) begin
                    r_bank <= !r_bank;
                end
            end
        end
    end

    // Header fields and running checksum
    always_ff @(posedge i_clk) begin
        if (rx_acc) begin
            case (r_phase)
                PH_LENGTH: begin
                    r_xor  <= i_rx_byte;
                    r_plen <= LEN_W'(i_rx_byte - FIXED_FIELDS);
                end
                PH_COUNT: begin
                    r_count <= i_rx_byte;
                    r_xor   <= r_xor ^ i_rx_byte;
                end
                PH_KIND: begin
                    r_kind <= i_rx_byte;
                    r_xor  <= r_xor ^ i_rx_byte;
                    r_fill <= '0;
                end
                PH_PAYLOAD: begin
                    r_xor  <= r_xor ^ i_rx_byte;
                    r_fill <= fill_next;
                end
                default: ;
            endcase
        end
    end

    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr.en |-> !r_busy[r_bank])
        else $error("payload written into a bank still being drained");

    a_good_holds_bank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && sum_ok) |=> r_busy[$past(r_bank)] && (r_bank != $past(r_bank)))
        else $error("good frame did not claim its bank");

    a_fill_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_fill < r_plen))
        else $error("payload fill beyond frame length");

endmodule

`default_nettype wire

FILE: sv/sfpx_queue.sv
// ----------------------------------------------------------------------------
// sfpx_queue
// Two-entry descriptor queue between the front parser and the back drain.
// ----------------------------------------------------------------------------
`default_nettype none

module sfpx_queue
    import sfpx_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_desc i_desc,
    output logic       o_full,
    input  wire logic  i_pop,
    output logic       o_empty,
    output t_desc      o_head
);

    t_desc      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_head  = r_mem[r_rp];

    // Store pushed descriptors
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_desc;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

`default_nettype wire

FILE: sv/sfpx_back.sv
// ----------------------------------------------------------------------------
// sfpx_back
// Holds the two-bank payload buffer and drains one queued frame at a time
// into the registered result port.
// ----------------------------------------------------------------------------
`default_nettype none

module sfpx_back
    import sfpx_pkg::*;
#(
    parameter int PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_empty,
    input  wire t_desc i_head,
    output logic       o_pop,
    input  wire t_wr   i_wr,
    output t_free      o_free,
    output logic       o_res_valid,
    input  wire logic  i_res_ready,
    output logic [7:0] o_payload_byte,
    output logic [5:0] o_byte_index,
    output logic       o_last_byte,
    output logic [7:0] o_frame_kind,
    output logic [7:0] o_frame_count,
    output logic       o_checksum_ok,
    output logic [31:0] o_good_frames,
    output logic [31:0] o_bad_frames
);

    localparam int IW    = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
    localparam int AW    = IW + 1;
    localparam int WORDS = 2 * (1 << IW);

    logic [7:0]       r_mem [WORDS];
    logic [7:0]       r_rdata;
    t_bstate          r_state, n_state;
    t_desc            r_desc;
    logic [LEN_W-1:0] r_idx;
    logic [7:0]       r_pay;
    logic [5:0]       r_index;
    logic             r_last;

    logic             res_acc;
    logic [LEN_W-1:0] idx_next;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;

    assign res_acc  = o_res_valid && i_res_ready;
    assign idx_next = r_idx + LEN_W'(1);

    // Next drain state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    n_state = i_head.ok ? B_LOAD : B_OUT;
                end
            end
            B_LOAD: n_state = B_OUT;
            B_OUT: begin
                if (res_acc) begin
                    n_state = r_last ? B_IDLE : B_LOAD;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    // Pop, buffer reads and bank release
    always_comb begin
        o_pop       = (r_state == B_IDLE) && !i_empty;
        o_res_valid = (r_state == B_OUT);
        rd_en       = 1'b0;
        rd_addr     = '0;
        if (o_pop && i_head.ok) begin
            rd_en   = 1'b1;
            rd_addr = {i_head.bank, IW'(0)};
        end else if ((r_state == B_OUT) && res_acc && !r_last) begin
            rd_en   = 1'b1;
            rd_addr = {r_desc.bank, idx_next[IW-1:0]};
        end
        o_free.valid = (r_state == B_OUT) && res_acc && r_last && r_desc.ok;
        o_free.bank  = r_desc.bank;
    end

    // Payload buffer
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[{i_wr.bank, i_wr.idx[IW-1:0]}] <= i_wr.data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // Drain state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Descriptor, index and result register
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_desc  <= i_head;
            r_idx   <= '0;
            r_pay   <= '0;
            r_index <= '0;
            r_last  <= 1'b1;
        end else if (r_state == B_LOAD) begin
            r_pay   <= r_rdata;
            r_index <= 6'(r_idx);
            r_last  <= (idx_next == r_desc.len);
        end else if ((r_state == B_OUT) && res_acc && !r_last) begin
            r_idx <= idx_next;
        end
    end

    assign o_payload_byte = r_pay;
    assign o_byte_index   = r_index;
    assign o_last_byte    = r_last;
    assign o_frame_kind   = r_desc.kind;
    assign o_frame_count  = r_desc.count;
    assign o_checksum_ok  = r_desc.ok;
    assign o_good_frames  = r_desc.good;
    assign o_bad_frames   = r_desc.bad;

    a_bad_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_checksum_ok) |-> (o_last_byte && (o_payload_byte == 8'd0)))
        else $error("bad frame result not a single zero result");

    a_idx_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == B_LOAD) || (o_res_valid && o_checksum_ok)) |-> (r_idx < r_desc.len))
        else $error("drain index beyond frame length");

    a_read_then_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |=> (r_state == B_LOAD))
        else $error("buffer read not followed by result load");

endmodule

`default_nettype wire

FILE: sv/serial_frame_parser_xor_core.sv
// ----------------------------------------------------------------------------
// serial_frame_parser_xor_core
// A good frame's first result is registered through the queue, the payload buffer
//   read and the result load; a bad-checksum result skips the buffer read and load.
// Throughput: the parser takes one byte per cycle; results drain one byte at a
//   time, each after its registered payload buffer read and load. Bytes stall only
//   while both payload banks hold undelivered frames or the two-entry queue is full.
// Reset: synchronous, active low; clears phase, counters, ids and queue.
//   The payload buffer is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_frame_parser_xor_core
    import sfpx_pkg::*;
#(
    parameter int PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [7:0]           i_cfg_data,
    output logic                      o_cfg_ready,
    input  wire logic                 i_rx_valid,
    input  wire logic [7:0]           i_rx_byte,
    output logic                      o_rx_ready,
    output logic                      o_res_valid,
    input  wire logic                 i_res_ready,
    output logic [7:0]                o_payload_byte,
    output logic [5:0]                o_byte_index,
    output logic                      o_last_byte,
    output logic [7:0]                o_frame_kind,
    output logic [7:0]                o_frame_count,
    output logic                      o_checksum_ok,
    output logic [31:0]               o_good_frames,
    output logic [31:0]               o_bad_frames
);

    logic  q_full, q_empty, push, pop;
    t_desc push_desc, head_desc;
    t_wr   wr;
    t_free free;

    // Parse and classify incoming bytes
    sfpx_front #(
        .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .i_rx_valid  (i_rx_valid),
        .i_rx_byte   (i_rx_byte),
        .o_rx_ready  (o_rx_ready),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_desc      (push_desc),
        .o_wr        (wr),
        .i_free      (free)
    );

    // Hold finished frames between the two sides
    sfpx_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (push_desc),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_head  (head_desc)
    );

    // Drain frames into results
    sfpx_back #(
        .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (q_empty),
        .i_head         (head_desc),
        .o_pop          (pop),
        .i_wr           (wr),
        .o_free         (free),
        .o_res_valid    (o_res_valid),
        .i_res_ready    (i_res_ready),
        .o_payload_byte (o_payload_byte),
        .o_byte_index   (o_byte_index),
        .o_last_byte    (o_last_byte),
        .o_frame_kind   (o_frame_kind),
        .o_frame_count  (o_frame_count),
        .o_checksum_ok  (o_checksum_ok),
        .o_good_frames  (o_good_frames),
        .o_bad_frames   (o_bad_frames)
    );

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives serial bytes into serial_frame_parser_xor_core and checks each
// result transfer against an in-bench frame parser. Covers framing aborts,
// checksum errors, id matching under several id settings, full-depth
// payloads and random stalls on both channels.
// ----------------------------------------------------------------------------
module testbench
    import sfpx_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE_CYCLES = 16;

    // Expected result of one transfer on the result channel
    typedef struct {
        logic [7:0]  payload;
        logic [5:0]  index;
        logic        last;
        logic [7:0]  kind;
        logic [7:0]  count;
        logic        ok;
        logic [31:0] good;
        logic [31:0] bad;
    } t_frame_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [7:0]           i_cfg_data = '0;
    logic                 o_cfg_ready;
    logic                 i_rx_valid = 1'b0;
    logic [7:0]           i_rx_byte = '0;
    logic                 o_rx_ready;
    logic                 o_res_valid;
    logic                 i_res_ready = 1'b0;
    logic [7:0]           o_payload_byte;
    logic [5:0]           o_byte_index;
    logic                 o_last_byte;
    logic [7:0]           o_frame_kind;
    logic [7:0]           o_frame_count;
    logic                 o_checksum_ok;
    logic [31:0]          o_good_frames;
    logic [31:0]          o_bad_frames;

    // Parser tracking state
    t_phase      trk_phase = PH_START1;
    logic [7:0]  trk_len = '0;
    logic [7:0]  trk_count = '0;
    logic [7:0]  trk_kind = '0;
    logic [7:0]  trk_xor = '0;
    logic [6:0]  trk_fill = '0;
    logic [7:0]  trk_store [PAYLOAD_DEPTH_DEF];
    logic [31:0] trk_good = '0;
    logic [31:0] trk_bad = '0;
    logic [7:0]  cfg_id [3] = '{8'h00, 8'h00, 8'h00};

    t_frame_result pending_results [$];

    int  errors = 0;
    int  cycles = 0;
    int  bytes_sent = 0;
    int  sink_hold = 0;
    bit  idle_on = 1'b1;

    serial_frame_parser_xor_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_cfg_ready    (o_cfg_ready),
        .i_rx_valid     (i_rx_valid),
        .i_rx_byte      (i_rx_byte),
        .o_rx_ready     (o_rx_ready),
        .o_res_valid    (o_res_valid),
        .i_res_ready    (i_res_ready),
        .o_payload_byte (o_payload_byte),
        .o_byte_index   (o_byte_index),
        .o_last_byte    (o_last_byte),
        .o_frame_kind   (o_frame_kind),
        .o_frame_count  (o_frame_count),
        .o_checksum_ok  (o_checksum_ok),
        .o_good_frames  (o_good_frames),
        .o_bad_frames   (o_bad_frames)
    );

    always #10 i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Stall the result channel in random bursts
    always @(posedge i_clk) begin
        if (idle_on && sink_hold == 0 && $urandom_range(0, 7) == 0)
            sink_hold = $urandom_range(1, 14);
        if (sink_hold != 0) begin
            sink_hold--;
            i_res_ready <= 1'b0;
        end else begin
            i_res_ready <= 1'b1;
        end
    end

    function automatic bit id_known(input logic [7:0] id);
        return id == cfg_id[0] || id == cfg_id[1] || id == cfg_id[2];
    endfunction

    task automatic push_result(input logic [7:0] data, input logic [5:0] idx,
                               input logic last, input logic ok);
        t_frame_result r;
        r.payload = data;
        r.index   = idx;
        r.last    = last;
        r.kind    = trk_kind;
        r.count   = trk_count;
        r.ok      = ok;
        r.good    = trk_good;
        r.bad     = trk_bad;
        pending_results.push_back(r);
    endtask

    // Advance the parser tracking by one received byte
    task automatic parse_rx_byte(input logic [7:0] c);
        int n;
        case (trk_phase)
            PH_START1: begin
                if (c == START_FIRST) begin
                    trk_len   = '0;
                    trk_count = '0;
                    trk_kind  = '0;
                    trk_xor   = '0;
                    trk_fill  = '0;
                    trk_phase = PH_START2;
                end
            end
            PH_START2: trk_phase = (c == START_SECOND) ? PH_LENGTH : PH_START1;
            PH_LENGTH: begin
                if (c < FIXED_FIELDS + 1 || c > PAYLOAD_DEPTH_DEF + FIXED_FIELDS) begin
                    trk_phase = PH_START1;
                end else begin
                    trk_len   = c;
                    trk_xor   = c;
                    trk_phase = PH_COUNT;
                end
            end
            PH_COUNT: begin
                trk_count = c;
                trk_xor   = trk_xor ^ c;
                trk_phase = PH_KIND;
            end
            PH_KIND: begin
                if (id_known(c)) begin
                    trk_kind  = c;
                    trk_xor   = trk_xor ^ c;
                    trk_fill  = '0;
                    trk_phase = PH_PAYLOAD;
                end else begin
                    trk_phase = PH_START1;
                end
            end
            PH_PAYLOAD: begin
                if (trk_fill < PAYLOAD_DEPTH_DEF)
                    trk_store[trk_fill[5:0]] = c;
                trk_xor  = trk_xor ^ c;
                trk_fill = trk_fill + 7'd1;
                if ({1'b0, trk_fill} >= trk_len - FIXED_FIELDS)
                    trk_phase = PH_CHECK;
            end
            PH_CHECK: begin
                trk_phase = PH_START1;
                if (c == trk_xor) begin
                    n = (trk_fill > PAYLOAD_DEPTH_DEF) ? PAYLOAD_DEPTH_DEF : trk_fill;
                    trk_good = trk_good + 32'd1;
                    for (int i = 0; i < n; i++)
                        push_result(trk_store[i], 6'(i), i + 1 == n, 1'b1);
                end else begin
                    trk_bad = trk_bad + 32'd1;
                    push_result(8'h00, 6'd0, 1'b1, 1'b0);
                end
            end
            default: trk_phase = PH_START1;
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // Compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_frame_result want;
        if (i_rst_n && o_res_valid && i_res_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result expected none, got payload_byte %0h index %0h",
                         $time, o_payload_byte, o_byte_index);
                errors++;
            end else begin
                want = pending_results.pop_front();
                check_field("payload_byte", want.payload, o_payload_byte);
                check_field("byte_index", want.index, o_byte_index);
                check_field("last_byte", want.last, o_last_byte);
                check_field("frame_kind", want.kind, o_frame_kind);
                check_field("frame_count", want.count, o_frame_count);
                check_field("checksum_ok", want.ok, o_checksum_ok);
                check_field("good_frames", want.good, o_good_frames);
                check_field("bad_frames", want.bad, o_bad_frames);
            end
        end
    end

    // Transfer one byte, with an optional idle gap ahead of it
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 14) : 0;
        if (gap != 0) begin
            i_rx_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (!o_rx_ready) @(posedge i_clk);
        parse_rx_byte(b);
        bytes_sent++;
    endtask

    // Hold the byte stream until every expected result is out
    task automatic wait_drained();
        i_rx_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cfg_id[idx] = val;
    endtask

    task automatic set_ids(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c);
        wait_drained();
        write_reg(CFG_ID_SYS, a);
        write_reg(CFG_ID_INERTIAL, b);
        write_reg(CFG_ID_LIGHT_MOTOR, c);
        i_cfg_valid <= 1'b0;
    endtask

    // Send a complete frame with random count and payload
    task automatic send_frame(input int len, input logic [7:0] kind, input bit bad_sum);
        logic [7:0] cnt, frame_sum, b;
        cnt = 8'($urandom_range(0, 255));
        frame_sum = 8'(len) ^ cnt ^ kind;
        send_byte(START_FIRST);
        send_byte(START_SECOND);
        send_byte(8'(len));
        send_byte(cnt);
        send_byte(kind);
        for (int i = 0; i < len - 3; i++) begin
            b = 8'($urandom_range(0, 255));
            frame_sum = frame_sum ^ b;
            send_byte(b);
        end
        if (bad_sum)
            frame_sum = frame_sum ^ 8'($urandom_range(1, 255));
        send_byte(frame_sum);
    endtask

    // Mostly well-formed frames, the rest bad checksums, unknown ids, broken framing and noise
    task automatic send_random_frame();
        int pick, len;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        len  = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 67) : $urandom_range(4, 12);
        if (pick < 70) begin
            send_frame(len, cfg_id[$urandom_range(0, 2)], 1'b0);
        end else if (pick < 78) begin
            send_frame(len, cfg_id[$urandom_range(0, 2)], 1'b1);
        end else if (pick < 83) begin
            send_byte(START_FIRST);
            send_byte(START_SECOND);
            send_byte($urandom_range(0, 1) ? 8'($urandom_range(0, 3))
                                           : 8'($urandom_range(68, 255)));
        end else if (pick < 88) begin
            do b = 8'($urandom_range(0, 255)); while (id_known(b));
            send_frame(len, b, 1'b0);
        end else if (pick < 93) begin
            do b = 8'($urandom_range(0, 255)); while (b == START_SECOND);
            send_byte(START_FIRST);
            send_byte(b);
        end else begin
            repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic run_random(input int target);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < target) send_random_frame();
    endtask

    // Reset ids are all zero: good frame with extreme count and payload
    task automatic test_good_frame();
        send_byte(START_FIRST);
        send_byte(START_SECOND);
        send_byte(8'h05);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h05);
    endtask

    task automatic test_bad_checksum();
        send_byte(START_FIRST);
        send_byte(START_SECOND);
        send_byte(8'h04);
        send_byte(8'h01);
        send_byte(8'h00);
        send_byte(8'h5A);
        send_byte(8'h5E);
    endtask

    // Wrong second start, short and long lengths, unknown id
    task automatic test_framing_aborts();
        send_byte(START_FIRST);
        send_byte(START_FIRST);
        send_byte(START_SECOND);
        send_byte(START_FIRST);
        send_byte(START_SECOND);
        send_byte(8'h03);
        send_byte(START_FIRST);
        send_byte(START_SECOND);
        send_byte(8'h44);
        send_byte(START_FIRST);
        send_byte(START_SECOND);
        send_byte(8'h04);
        send_byte(8'h00);
        send_byte(8'h77);
    endtask

    // Distinct ids, with one pause until all results are out
    task automatic test_distinct_ids();
        set_ids(8'(8'h11 + $urandom_range(0, 15)), 8'(8'h42 + $urandom_range(0, 15)),
                8'(8'hA0 + $urandom_range(0, 15)));
        run_random(40);
        wait_drained();
        run_random(40);
    endtask

    // Full-depth payloads, one with a bad checksum, the first length too long, the shortest frame
    task automatic test_max_length();
        send_frame(PAYLOAD_DEPTH_DEF + 3, cfg_id[0], 1'b0);
        send_frame(PAYLOAD_DEPTH_DEF + 3, cfg_id[2], 1'b1);
        send_byte(START_FIRST);
        send_byte(START_SECOND);
        send_byte(8'(PAYLOAD_DEPTH_DEF + 4));
        send_frame(4, cfg_id[1], 1'b0);
    endtask

    task automatic test_duplicate_ids();
        set_ids(8'hFF, 8'hFF, 8'hFF);
        run_random(40);
    endtask

    task automatic test_mixed_ids();
        set_ids(8'h00, 8'hFF, 8'($urandom_range(0, 255)));
        run_random(60);
    endtask

    // Last stretch runs with no idling on either side
    task automatic test_quiet_tail();
        set_ids(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)));
        idle_on = 1'b0;
        run_random(70);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_good_frame();
        test_bad_checksum();
        test_framing_aborts();
        test_distinct_ids();
        test_max_length();
        test_duplicate_ids();
        test_mixed_ids();
        test_quiet_tail();

        wait_drained();
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
